// ===== sv/soet_pkg.sv =====
// ----------------------------------------------------------------------------
// soet_pkg
// Shared widths, codes, stage payload types and helpers of the overlap tracker
// ----------------------------------------------------------------------------
package soet_pkg;

  localparam int PAIR_COUNT  = 1024;
  localparam int COORD_WIDTH = 24;
  localparam int SIZE_WIDTH  = 23;
  localparam int KIND_WIDTH  = 2;
  localparam int INDEX_WIDTH = 10;

  localparam int IDX_W = $clog2(PAIR_COUNT);
  // cap centers reach y +- (h - r): two more bits than a position
  localparam int PT_W  = COORD_WIDTH + 2;
  localparam int LIM_W = SIZE_WIDTH + 1;
  localparam int SQ_W  = 2 * PT_W;
  localparam int LSQ_W = 2 * LIM_W;

  localparam logic [KIND_WIDTH-1:0] KIND_BOX     = 2'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_CIRCLE  = 2'd1;
  localparam logic [KIND_WIDTH-1:0] KIND_CAPSULE = 2'd2;
  // spare code, handled as a box
  localparam logic [KIND_WIDTH-1:0] KIND_OTHER   = 2'd3;

  typedef enum logic [1:0] {
    MODE_DIST,    // cap center / circle center distances
    MODE_CLAMP,   // circle against box, clamped closest point
    MODE_BOXBOX,  // axis separation of two boxes
    MODE_PIB      // capsule points inside a box
  } mode_t;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [SIZE_WIDTH-1:0]         sz_t;
  typedef logic signed [SIZE_WIDTH:0]    off_t;
  typedef logic signed [PT_W-1:0]        pt_t;
  typedef logic [PT_W-1:0]               mag_t;
  typedef logic [LIM_W-1:0]              lim_t;
  typedef logic [SQ_W-1:0]               sq_t;
  typedef logic [LSQ_W-1:0]              lsq_t;
  typedef logic [IDX_W-1:0]              idx_t;

  typedef struct packed {
    logic [KIND_WIDTH-1:0] kind;
    coord_t                x;
    coord_t                y;
    sz_t                   r;
    sz_t                   h;
  } shape_t;

  typedef struct packed {
    idx_t   idx;
    shape_t a;
    shape_t b;
  } req_t;

  typedef struct packed {
    idx_t   idx;
    mode_t  mode;
    coord_t c_x;
    coord_t c_y;
    sz_t    c_r;
    sz_t    c_h;
    off_t   c_off;
    coord_t o_x;
    coord_t o_y;
    sz_t    o_r;
    sz_t    o_h;
    off_t   o_off;
  } roles_t;

  typedef struct packed {
    idx_t  idx;
    mode_t mode;
    pt_t   cx;
    pt_t   cy;
    pt_t   ctop;
    pt_t   cbot;
    pt_t   ox;
    pt_t   oy;
    pt_t   otop;
    pt_t   obot;
    pt_t   xlo;
    pt_t   xhi;
    pt_t   ylo;
    pt_t   yhi;
    lim_t  lim;
    lim_t  hlim;
  } points_t;

  typedef struct packed {
    idx_t       idx;
    mode_t      mode;
    mag_t       mx;
    mag_t [3:0] my;
    lim_t       lim;
    lim_t       hlim;
  } mags_t;

  typedef struct packed {
    idx_t       idx;
    mode_t      mode;
    sq_t        sx;
    sq_t  [3:0] sy;
    lsq_t       sl;
    logic       bx_ok;
    logic [3:0] by_ok;
  } sqr_t;

  function automatic mag_t absdiff(pt_t p, pt_t q);
    logic signed [PT_W:0] d;
    logic signed [PT_W:0] n;
    d = (PT_W+1)'(p) - (PT_W+1)'(q);
    n = -d;
    return d[PT_W] ? n[PT_W-1:0] : d[PT_W-1:0];
  endfunction

  function automatic pt_t clampv(pt_t v, pt_t lo, pt_t hi);
    pt_t r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== sv/soet_if.sv =====
// ----------------------------------------------------------------------------
// soet channel interfaces
// Request channel (one shape pair) and result channel (overlap and events)
// ----------------------------------------------------------------------------
interface soet_req_if import soet_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [INDEX_WIDTH-1:0] pair_index;
  logic [KIND_WIDTH-1:0]  a_kind;
  coord_t                 a_x;
  coord_t                 a_y;
  sz_t                    a_radius_or_half_width;
  sz_t                    a_half_height;
  logic [KIND_WIDTH-1:0]  b_kind;
  coord_t                 b_x;
  coord_t                 b_y;
  sz_t                    b_radius_or_half_width;
  sz_t                    b_half_height;

  modport source (
    output valid, pair_index, a_kind, a_x, a_y, a_radius_or_half_width, a_half_height,
    output b_kind, b_x, b_y, b_radius_or_half_width, b_half_height,
    input  ready
  );
  modport sink (
    input  valid, pair_index, a_kind, a_x, a_y, a_radius_or_half_width, a_half_height,
    input  b_kind, b_x, b_y, b_radius_or_half_width, b_half_height,
    output ready
  );
endinterface

interface soet_rsp_if ();
  logic valid;
  logic ready;
  logic overlapping;
  logic begin_event;
  logic end_event;

  modport source (output valid, overlapping, begin_event, end_event, input ready);
  modport sink (input valid, overlapping, begin_event, end_event, output ready);
endinterface

// ===== sv/shape_overlap_event_tracker.sv =====
// throughput: one request per cycle; a stalled result freezes every stage
// reset: synchronous; then a clearing pass zeroes the per-pair history memory,
//   one entry a cycle, with pair.ready held low
// ----------------------------------------------------------------------------
// shape_overlap_event_tracker
// Tests one pair of 2-D shapes (box, circle, vertical capsule) per request and
// reports overlap with begin and end events against the pair's last test
// ----------------------------------------------------------------------------
module shape_overlap_event_tracker import soet_pkg::*; (
  input logic         clk,
  input logic         rst,
  soet_req_if.sink    pair,
  soet_rsp_if.source  result
);

  // pipeline map
  //   s1  request register
  //   s2  reference shape and test mode (box-box, clamp, point-in-box, distance)
  //   s3  cap centers, box bounds, distance and extent limits
  //   s4  coordinate differences as magnitudes, clamp to box for circles
  //   s5  squares and extent checks; history read issued on entry
  //   s6  squared-sum compare, history forward and write, result register

  logic    en;
  logic    busy;
  logic    s1_v;
  req_t    s1;
  logic    pts_v;
  points_t pts;
  logic    mag_v;
  idx_t    mag_idx;
  logic    sq_v;
  sqr_t    sq;
  logic    res_v;

  // whole pipe moves unless a result is waiting and not taken
  assign en         = !res_v || result.ready;
  assign pair.ready = en && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= pair.valid && pair.ready;
    end
    if (en) begin
      // pair index wraps to the history depth
      s1.idx    <= pair.pair_index[IDX_W-1:0];
      s1.a.kind <= pair.a_kind;
      s1.a.x    <= pair.a_x;
      s1.a.y    <= pair.a_y;
      s1.a.r    <= pair.a_radius_or_half_width;
      s1.a.h    <= pair.a_half_height;
      s1.b.kind <= pair.b_kind;
      s1.b.x    <= pair.b_x;
      s1.b.y    <= pair.b_y;
      s1.b.r    <= pair.b_radius_or_half_width;
      s1.b.h    <= pair.b_half_height;
    end
  end

  // s2, s3
  soet_prep u_prep (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .in_v  (s1_v),
    .item  (s1),
    .out_v (pts_v),
    .pts   (pts)
  );

  // s4, s5
  soet_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (pts_v),
    .pts     (pts),
    .mag_v   (mag_v),
    .mag_idx (mag_idx),
    .out_v   (sq_v),
    .sq      (sq)
  );

  // s6 and the history memory
  soet_track u_track (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .rd_v        (mag_v),
    .rd_idx      (mag_idx),
    .in_v        (sq_v),
    .sq          (sq),
    .busy        (busy),
    .out_v       (res_v),
    .overlapping (result.overlapping),
    .begin_event (result.begin_event),
    .end_event   (result.end_event)
  );

  assign result.valid = res_v;

endmodule

// ===== sv/soet_ram.sv =====
// ----------------------------------------------------------------------------
// soet_ram
// Generic single write port, single read port RAM with registered read
// ----------------------------------------------------------------------------
module soet_ram #(
  parameter int  WIDTH = 1,
  parameter int  DEPTH = 2,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/soet_prep.sv =====
// ----------------------------------------------------------------------------
// soet_prep
// Role selection and test mode (stage 2), cap centers, limits, box bounds
// (stage 3)
// ----------------------------------------------------------------------------
module soet_prep import soet_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    in_v,
  input  req_t    item,
  output logic    out_v,
  output points_t pts
);

  logic    a_circ, a_cap, a_box, b_circ, b_cap, b_box;
  logic    swap, c_cap, c_box, o_box;
  shape_t  c, o;
  roles_t  role_next, role;
  logic    role_v;
  points_t pts_next;
  pt_t     o_rx, o_hy;

  // stage 2: c is the reference shape, o the other one
  always_comb begin
    a_circ = (item.a.kind == KIND_CIRCLE);
    a_cap  = (item.a.kind == KIND_CAPSULE);
    a_box  = !a_circ && !a_cap;
    b_circ = (item.b.kind == KIND_CIRCLE);
    b_cap  = (item.b.kind == KIND_CAPSULE);
    b_box  = !b_circ && !b_cap;
    swap   = (b_cap && !a_cap) || (a_box && b_circ);
    c      = swap ? item.b : item.a;
    o      = swap ? item.a : item.b;
    c_cap  = swap ? b_cap : a_cap;
    c_box  = swap ? b_box : a_box;
    o_box  = swap ? a_box : b_box;

    role_next.idx = item.idx;
    priority if (c_box && o_box) begin
      role_next.mode = MODE_BOXBOX;
    end else if (o_box) begin
      role_next.mode = c_cap ? MODE_PIB : MODE_CLAMP;
    end else begin
      role_next.mode = MODE_DIST;
    end
    role_next.c_x   = c.x;
    role_next.c_y   = c.y;
    role_next.c_r   = c.r;
    role_next.c_h   = c.h;
    role_next.c_off = c_cap ? ($signed({1'b0, c.h}) - $signed({1'b0, c.r})) : '0;
    role_next.o_x   = o.x;
    role_next.o_y   = o.y;
    role_next.o_r   = o.r;
    role_next.o_h   = o.h;
    role_next.o_off = (swap ? a_cap : b_cap) ?
                      ($signed({1'b0, o.h}) - $signed({1'b0, o.r})) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      role_v <= 1'b0;
    end else if (en) begin
      role_v <= in_v;
    end
    if (en) begin
      role <= role_next;
    end
  end

  // stage 3: cap centers, box bounds and limits
  always_comb begin
    o_rx          = PT_W'(role.o_r);
    o_hy          = PT_W'(role.o_h);
    pts_next.idx  = role.idx;
    pts_next.mode = role.mode;
    pts_next.cx   = PT_W'(role.c_x);
    pts_next.cy   = PT_W'(role.c_y);
    pts_next.ctop = PT_W'(role.c_y) + PT_W'(role.c_off);
    pts_next.cbot = PT_W'(role.c_y) - PT_W'(role.c_off);
    pts_next.ox   = PT_W'(role.o_x);
    pts_next.oy   = PT_W'(role.o_y);
    pts_next.otop = PT_W'(role.o_y) + PT_W'(role.o_off);
    pts_next.obot = PT_W'(role.o_y) - PT_W'(role.o_off);
    pts_next.xlo  = PT_W'(role.o_x) - o_rx;
    pts_next.xhi  = PT_W'(role.o_x) + o_rx;
    pts_next.ylo  = PT_W'(role.o_y) - o_hy;
    pts_next.yhi  = PT_W'(role.o_y) + o_hy;
    unique case (role.mode)
      MODE_CLAMP: pts_next.lim = LIM_W'(role.c_r);
      MODE_PIB:   pts_next.lim = LIM_W'(role.o_r);
      default:    pts_next.lim = LIM_W'(role.c_r) + LIM_W'(role.o_r);
    endcase
    pts_next.hlim = (role.mode == MODE_BOXBOX) ?
                    (LIM_W'(role.c_h) + LIM_W'(role.o_h)) : LIM_W'(role.o_h);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= role_v;
    end
    if (en) begin
      pts <= pts_next;
    end
  end

endmodule

// ===== sv/soet_dist.sv =====
// ----------------------------------------------------------------------------
// soet_dist
// Distance magnitudes (stage 4), squares and box bound checks (stage 5)
// ----------------------------------------------------------------------------
module soet_dist import soet_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    in_v,
  input  points_t pts,
  output logic    mag_v,
  output idx_t    mag_idx,
  output logic    out_v,
  output sqr_t    sq
);

  mags_t mg_next, mg;
  sqr_t  sq_next;
  pt_t   qx, qy;
  pt_t   yc [4];
  pt_t   yo [4];

  // stage 4
  always_comb begin
    qx = (pts.mode == MODE_CLAMP) ? clampv(pts.cx, pts.xlo, pts.xhi) : pts.ox;
    qy = clampv(pts.cy, pts.ylo, pts.yhi);
    unique case (pts.mode)
      MODE_DIST: begin
        yc = '{pts.ctop, pts.ctop, pts.cbot, pts.cbot};
        yo = '{pts.otop, pts.obot, pts.otop, pts.obot};
      end
      MODE_CLAMP: begin
        yc = '{pts.cy, pts.cy, pts.cy, pts.cy};
        yo = '{qy, qy, qy, qy};
      end
      MODE_BOXBOX: begin
        yc = '{pts.cy, pts.cy, pts.cy, pts.cy};
        yo = '{pts.oy, pts.oy, pts.oy, pts.oy};
      end
      MODE_PIB: begin
        yc = '{pts.ctop, pts.cbot, pts.cy, pts.cy};
        yo = '{pts.oy, pts.oy, pts.oy, pts.oy};
      end
    endcase
    mg_next.idx  = pts.idx;
    mg_next.mode = pts.mode;
    mg_next.mx   = absdiff(pts.cx, qx);
    for (int k = 0; k < 4; k++) begin
      mg_next.my[k] = absdiff(yc[k], yo[k]);
    end
    mg_next.lim  = pts.lim;
    mg_next.hlim = pts.hlim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_v <= 1'b0;
    end else if (en) begin
      mag_v <= in_v;
    end
    if (en) begin
      mg <= mg_next;
    end
  end

  assign mag_idx = mg.idx;

  // stage 5
  always_comb begin
    sq_next.idx   = mg.idx;
    sq_next.mode  = mg.mode;
    sq_next.sx    = SQ_W'(mg.mx) * SQ_W'(mg.mx);
    sq_next.sl    = LSQ_W'(mg.lim) * LSQ_W'(mg.lim);
    sq_next.bx_ok = (mg.mx <= PT_W'(mg.lim));
    for (int k = 0; k < 4; k++) begin
      sq_next.sy[k]    = SQ_W'(mg.my[k]) * SQ_W'(mg.my[k]);
      sq_next.by_ok[k] = (mg.my[k] <= PT_W'(mg.hlim));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= mag_v;
    end
    if (en) begin
      sq <= sq_next;
    end
  end

endmodule

// ===== sv/soet_track.sv =====
// ----------------------------------------------------------------------------
// soet_track
// Overlap decision, per-pair history memory with forwarding, result register
// ----------------------------------------------------------------------------
module soet_track import soet_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic rd_v,
  input  idx_t rd_idx,
  input  logic in_v,
  input  sqr_t sq,
  output logic busy,
  output logic out_v,
  output logic overlapping,
  output logic begin_event,
  output logic end_event
);

  idx_t                clr_addr;
  idx_t                last_idx;
  logic [3:0]          fits;
  logic                now, prev;
  logic                we;
  idx_t                waddr;
  logic [0:0]          wdata;
  logic [0:0]          rdata;

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == IDX_W'(PAIR_COUNT - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      fits[k] = ((SQ_W+1)'(sq.sx) + (SQ_W+1)'(sq.sy[k])) <= (SQ_W+1)'(sq.sl);
    end
    unique case (sq.mode)
      MODE_BOXBOX: now = sq.bx_ok && sq.by_ok[0];
      MODE_PIB:    now = sq.bx_ok && (|sq.by_ok[2:0]);
      default:     now = |fits;
    endcase
    // the item just ahead was written on the edge this one was read
    prev  = (out_v && (last_idx == sq.idx)) ? overlapping : rdata[0];
    we    = busy || (en && in_v);
    waddr = busy ? clr_addr : sq.idx;
    wdata = busy ? 1'b0 : now;
  end

  soet_ram #(
    .WIDTH (1),
    .DEPTH (PAIR_COUNT)
  ) u_hist (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (en && rd_v),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
    if (en) begin
      last_idx    <= sq.idx;
      overlapping <= now;
      begin_event <= now && !prev;
      end_event   <= prev && !now;
    end
  end

  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (rst)
    busy |-> (!in_v && !rd_v))
    else $error("item in flight during history clear");

  a_events_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_v |-> !(begin_event && end_event))
    else $error("begin and end event together");

  a_begin_needs_overlap: assert property (@(posedge clk) disable iff (rst)
    (out_v && begin_event) |-> overlapping)
    else $error("begin event without overlap");

  a_end_needs_clear: assert property (@(posedge clk) disable iff (rst)
    (out_v && end_event) |-> !overlapping)
    else $error("end event while overlapping");

endmodule
